// File: hdl/kmq_pkg.sv
// shared constants and types of the keyed message queue
`timescale 1ns / 1ps
package kmq_pkg;

	localparam int DEPTH = 64;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int KEY_W = 32;
	localparam int PAY_W = 32;
	localparam int ACT_W = 2;
	localparam int LIM_W = 7;
	localparam int IN_W = KEY_W + PAY_W;
	localparam int OUT_BITS = 1 + PAY_W + 1 + KEY_W + CNT_W;
	localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(50);

	localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
	localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_FIND   = 2'd2;

	typedef struct packed {
		logic capture;
		logic execute;
	} cmd_t;

endpackage

// File: hdl/kmq_ctrl.sv
// controller of the keyed message queue: accept, execute and output handshake
`timescale 1ns / 1ps
module kmq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	output kmq_pkg::cmd_t cmd
);
	import kmq_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic out_valid_q;
	logic out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign out_free = !out_valid_q || m_tready;

	assign cmd.capture = s_tvalid && (state_q == ST_IDLE);
	assign cmd.execute = (state_q == ST_EXEC) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cmd.execute) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: hdl/kmq_datapath.sv
// datapath of the keyed message queue: entry cells, key search, gap closing, result register
`timescale 1ns / 1ps
module kmq_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  kmq_pkg::cmd_t              cmd,
	input  logic [kmq_pkg::IN_W-1:0]   s_tdata,
	input  logic [kmq_pkg::ACT_W-1:0]  s_tuser,
	input  logic                       cfg_write,
	input  logic [kmq_pkg::LIM_W-1:0]  cfg_data,
	output logic [kmq_pkg::OUT_W-1:0]  m_tdata
);
	import kmq_pkg::*;

	logic [KEY_W-1:0] key_q [DEPTH];
	logic [PAY_W-1:0] pay_q [DEPTH];
	logic [KEY_W-1:0] up_key [DEPTH];
	logic [PAY_W-1:0] up_pay [DEPTH];
	logic [CNT_W-1:0] count_q;
	logic [LIM_W-1:0] limit_q;

	logic [ACT_W-1:0] act_s1;
	logic [KEY_W-1:0] key_s1;
	logic [PAY_W-1:0] pay_s1;
	logic [DEPTH-1:0] match_s1;

	logic [OUT_W-1:0] out_q;

	logic [DEPTH-1:0] rev;
	logic [DEPTH-1:0] rev_mask;
	logic [DEPTH-1:0] rev_sel;
	logic [DEPTH-1:0] sel;
	logic [DEPTH-1:0] ge;
	logic [DEPTH-1:0] shift_vec;
	logic             hit;
	logic [LIM_W-1:0] lim;
	logic [CNT_W-1:0] cnt_inc;
	logic             is_ins;
	logic             is_rem;
	logic             is_find;
	logic             ins_evict;
	logic             ins_self;
	logic             ins_write;
	logic [IDX_W-1:0] wr_idx;
	logic [CNT_W-1:0] wr_cnt;
	logic [CNT_W-1:0] count_nxt;
	logic [PAY_W-1:0] pay_sel;
	logic [KEY_W-1:0] ev_key;
	logic             found;
	logic [PAY_W-1:0] pay_out;

	// capture the item and compare its key against every live cell
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_s1 <= s_tuser;
			key_s1 <= s_tdata[KEY_W-1:0];
			pay_s1 <= s_tdata[IN_W-1:KEY_W];
			for (int i = 0; i < DEPTH; i++) begin
				match_s1[i] <= (key_q[i] == s_tdata[KEY_W-1:0]) && (CNT_W'(i) < count_q);
			end
		end
	end

	// newest match is the highest set bit: isolate it in the bit-reversed vector
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			rev[i] = match_s1[DEPTH-1-i];
		end
		rev_mask = rev ^ (rev - DEPTH'(1));
		rev_sel  = rev_mask & rev;
		for (int i = 0; i < DEPTH; i++) begin
			sel[i] = rev_sel[DEPTH-1-i];
			ge[i]  = rev_mask[DEPTH-1-i];
		end
		hit = |match_s1;
	end

	always_comb begin
		pay_sel = '0;
		for (int i = 0; i < DEPTH; i++) begin
			pay_sel = pay_sel | (pay_q[i] & {PAY_W{sel[i]}});
		end
	end

	always_comb begin
		lim       = (limit_q > LIM_W'(DEPTH)) ? LIM_W'(DEPTH) : limit_q;
		cnt_inc   = count_q + CNT_W'(1);
		is_ins    = (act_s1 == ACT_INSERT);
		is_rem    = (act_s1 == ACT_REMOVE);
		is_find   = (act_s1 == ACT_FIND);
		ins_evict = is_ins && (LIM_W'(cnt_inc) > lim);
		ins_self  = ins_evict && (count_q == '0);
		ins_write = is_ins && !ins_self;
		wr_cnt    = ins_evict ? (count_q - CNT_W'(1)) : count_q;
		wr_idx    = wr_cnt[IDX_W-1:0];

		if (ins_evict && !ins_self) begin
			shift_vec = '1;
		end else if (is_rem && hit) begin
			shift_vec = ge;
		end else begin
			shift_vec = '0;
		end

		if (ins_write && !ins_evict) begin
			count_nxt = cnt_inc;
		end else if (is_rem && hit) begin
			count_nxt = count_q - CNT_W'(1);
		end else begin
			count_nxt = count_q;
		end

		if (ins_self) begin
			ev_key = key_s1;
		end else if (ins_evict) begin
			ev_key = key_q[0];
		end else begin
			ev_key = '0;
		end

		found   = is_ins || ((is_rem || is_find) && hit);
		pay_out = (is_find && hit) ? pay_sel : '0;
	end

	// each cell below the top takes its upper neighbor when the gap closes; the top cell keeps its own
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		if (g == DEPTH - 1) begin : g_top
			assign up_key[g] = key_q[g];
			assign up_pay[g] = pay_q[g];
		end else begin : g_mid
			assign up_key[g] = key_q[g+1];
			assign up_pay[g] = pay_q[g+1];
		end

		always_ff @(posedge clk) begin
			if (cmd.execute) begin
				if (ins_write && (wr_idx == IDX_W'(g))) begin
					key_q[g] <= key_s1;
					pay_q[g] <= pay_s1;
				end else if (shift_vec[g]) begin
					key_q[g] <= up_key[g];
					pay_q[g] <= up_pay[g];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			limit_q <= LIMIT_RESET;
		end else begin
			if (cmd.execute) begin
				count_q <= count_nxt;
			end
			if (cfg_write) begin
				limit_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			out_q <= OUT_W'({count_nxt, ev_key, ins_evict, pay_out, found});
		end
	end

	assign m_tdata = out_q;

endmodule

// File: hdl/keyed_message_queue_unit.sv
// top level of the keyed message queue
//
// Ordered table of up to 64 entries (message number, payload word), oldest first.
// Input stream s_*: one transfer carries an action (s_tuser) with a message number
// and a payload word (s_tdata). Insert appends and evicts the oldest entry once the
// count passes entry_limit; remove deletes the newest entry with that number and
// closes the gap; find returns the newest matching payload.
// Output stream m_*: exactly one result transfer for every input transfer, in order.
// Config channel cfg_*: writes entry_limit (reset 50, values above 64 act as 64);
// write only while no action is in flight. cfg_ready is always high.
// The key compare against all cells is registered in the accept cycle; the execute
// cycle, which waits until the result register is free, resolves the newest match,
// shifts the cells and loads the result register. A new input is taken only after
// the current action has executed.
// Reset clears the entry count and restores the limit; no clearing pass is needed.
// While m_tready is low the result holds, one more input is taken and then held
// in its execute cycle until the result register frees.
`timescale 1ns / 1ps
module keyed_message_queue_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [kmq_pkg::IN_W-1:0]     s_tdata,  // msg_number, payload_in
	input  logic [kmq_pkg::ACT_W-1:0]    s_tuser,  // action
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [kmq_pkg::OUT_W-1:0]    m_tdata,  // found, payload_out, evicted,
	                                               // evicted_msg_number, entry_count, zero pad
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [kmq_pkg::LIM_W-1:0]    cfg_data  // entry_limit
);
	import kmq_pkg::*;

	cmd_t cmd;

	assign cfg_ready = 1'b1;

	kmq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	kmq_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_write (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.m_tdata   (m_tdata)
	);

endmodule

// File: hdl/kmq_checker.sv
// port-level checks of the keyed message queue, bound to the top level
`timescale 1ns / 1ps
module kmq_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [kmq_pkg::OUT_W-1:0]    m_tdata
);
	import kmq_pkg::*;

	// one action in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an action is in flight");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[OUT_BITS-1:OUT_BITS-CNT_W] <= CNT_W'(DEPTH)))
		else $error("entry count above depth");

	// an eviction only comes from an insert, which always reports found
	a_evict_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[PAY_W+1] |-> m_tdata[0])
		else $error("eviction without found");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[OUT_W-1:OUT_BITS] == '0))
		else $error("pad bits not zero");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

endmodule

bind keyed_message_queue_unit kmq_checker u_kmq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
